// ===== hdl/nks_pkg.sv =====
// shared types, codes and table layout for the k-mer statistics block
package nks_pkg;

  localparam int DIST_BINS_DEFAULT = 64;
  localparam int COUNTER_WIDTH_DEFAULT = 32;

  // request codes
  localparam logic [1:0] REQ_SYMBOL = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_CHAR = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;

  // table select codes
  localparam logic [2:0] SEL_K1   = 3'd0;
  localparam logic [2:0] SEL_K2   = 3'd1;
  localparam logic [2:0] SEL_K3   = 3'd2;
  localparam logic [2:0] SEL_K4   = 3'd3;
  localparam logic [2:0] SEL_K5   = 3'd4;
  localparam logic [2:0] SEL_HIST = 3'd5;
  localparam logic [2:0] SEL_MAXD = 3'd6;
  localparam logic [2:0] SEL_SEEN = 3'd7;

  // internal operation codes
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_SYMBOL = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // counter memory layout: k=1..5 tables, then the repeat histogram
  localparam int K1_BASE   = 0;
  localparam int K2_BASE   = 4;
  localparam int K3_BASE   = 20;
  localparam int K4_BASE   = 84;
  localparam int K5_BASE   = 340;
  localparam int HIST_BASE = 1364;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] status;
    logic [1:0] sym;
    logic [2:0] sel;
    logic [9:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } res_t;

endpackage

// ===== hdl/nks_front.sv =====
// front end: decodes requests, maps characters and range-checks reads
module nks_front import nks_pkg::*; #(
  parameter int DistanceBins = DIST_BINS_DEFAULT
) (
  input  logic [1:0] req_type,
  input  logic [7:0] symbol_char,
  input  logic [2:0] table_select,
  input  logic [9:0] read_index,
  output cmd_t       cmd
);

  localparam logic [12:0] HistLimit = 13'(4 * DistanceBins);

  logic [12:0] limit;
  logic        sym_ok;
  logic [1:0]  sym;

  // character to 2-bit code
  always_comb begin
    sym_ok = 1'b1;
    sym    = 2'd0;
    unique case (symbol_char)
      8'h41: sym = 2'd0;
      8'h43: sym = 2'd1;
      8'h47: sym = 2'd2;
      8'h54: sym = 2'd3;
      default: sym_ok = 1'b0;
    endcase
  end

  // size of the selected table
  always_comb begin
    unique case (table_select)
      SEL_K1:   limit = 13'd4;
      SEL_K2:   limit = 13'd16;
      SEL_K3:   limit = 13'd64;
      SEL_K4:   limit = 13'd256;
      SEL_K5:   limit = 13'd1024;
      SEL_HIST: limit = HistLimit;
      SEL_MAXD: limit = 13'd4;
      default:  limit = 13'd1;
    endcase
  end

  // classify
  always_comb begin
    cmd.op     = OP_NONE;
    cmd.status = STAT_OK;
    cmd.sym    = sym;
    cmd.sel    = table_select;
    cmd.idx    = read_index;
    unique case (req_type)
      REQ_SYMBOL: begin
        if (sym_ok) cmd.op = OP_SYMBOL;
        else cmd.status = STAT_BAD_CHAR;
      end
      REQ_READ: begin
        if ({3'd0, read_index} < limit) cmd.op = OP_READ;
        else cmd.status = STAT_RANGE;
      end
      REQ_CLEAR: cmd.op = OP_CLEAR;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/nks_fifo.sv =====
// two-entry queue used between front and back and on the result side
module nks_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  input  logic  rd,
  output item_t rdata,
  output logic  empty
);

  item_t      store [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = store[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      unique case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) store[wptr] <= wdata;
  end

endmodule

// ===== hdl/nks_back.sv =====
// back end: counter memory, per-symbol state and the update sequencer
module nks_back import nks_pkg::*; #(
  parameter int DistanceBins = DIST_BINS_DEFAULT,
  parameter int CounterWidth = COUNTER_WIDTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  localparam int MemDepth = HIST_BASE + 4 * DistanceBins;
  localparam int AW = $clog2(MemDepth);
  localparam int BW = $clog2(DistanceBins);
  localparam logic [AW-1:0] LastAddr = AW'(MemDepth - 1);
  localparam logic [AW-1:0] BinsA = AW'(DistanceBins);
  localparam logic [BW-1:0] TopBin = BW'(DistanceBins - 1);
  localparam logic [2:0] LastStep = 3'd5;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_RDATA = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [CounterWidth-1:0] mem [MemDepth];
  logic [CounterWidth-1:0] rdata;
  logic [CounterWidth-1:0] wdata;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic                    we;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] clr_addr;
  logic [2:0]    step;
  logic [1:0]    sym;
  logic [BW-1:0] dist_bin;

  logic [3:0]  pos_valid;
  logic [31:0] last_pos [4];
  logic [31:0] max_dist [4];
  logic [7:0]  recent;
  logic [31:0] seen;

  logic [31:0]   gap;
  logic          step_en;
  logic [AW-1:0] step_addr;
  logic [AW-1:0] read_addr;

  // counter memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign gap = seen - last_pos[sym];

  // which update a step performs and where
  always_comb begin
    step_en   = 1'b0;
    step_addr = '0;
    unique case (step)
      3'd0: begin
        step_en   = pos_valid[sym];
        step_addr = AW'(HIST_BASE) + AW'(sym) * BinsA + AW'(dist_bin);
      end
      3'd1: begin
        step_en   = 1'b1;
        step_addr = AW'(K1_BASE) + AW'(sym);
      end
      3'd2: begin
        step_en   = (seen > 32'd0);
        step_addr = AW'(K2_BASE) + AW'({sym, recent[7:6]});
      end
      3'd3: begin
        step_en   = (seen > 32'd1);
        step_addr = AW'(K3_BASE) + AW'({sym, recent[7:4]});
      end
      3'd4: begin
        step_en   = (seen > 32'd2);
        step_addr = AW'(K4_BASE) + AW'({sym, recent[7:2]});
      end
      default: begin
        step_en   = (seen > 32'd3);
        step_addr = AW'(K5_BASE) + AW'({sym, recent});
      end
    endcase
  end

  // memory address for a table read
  always_comb begin
    unique case (cmd.sel)
      SEL_K1:  read_addr = AW'(K1_BASE) + AW'(cmd.idx);
      SEL_K2:  read_addr = AW'(K2_BASE) + AW'(cmd.idx);
      SEL_K3:  read_addr = AW'(K3_BASE) + AW'(cmd.idx);
      SEL_K4:  read_addr = AW'(K4_BASE) + AW'(cmd.idx);
      SEL_K5:  read_addr = AW'(K5_BASE) + AW'(cmd.idx);
      default: read_addr = AW'(HIST_BASE) + AW'(cmd.idx);
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res.status = STAT_OK;
    res.value  = 32'd0;
    we         = 1'b0;
    waddr      = step_addr;
    wdata      = (rdata == '1) ? rdata : rdata + 1'b1;
    raddr      = step_addr;
    unique case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == LastAddr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        raddr = read_addr;
        if (!cmd_empty && !res_full) begin
          cmd_pop    = 1'b1;
          res.status = cmd.status;
          unique case (cmd.op)
            OP_SYMBOL: begin
              res_push   = 1'b1;
              state_next = ST_PREP;
            end
            OP_CLEAR: begin
              res_push   = 1'b1;
              state_next = ST_CLR;
            end
            OP_READ: begin
              if (cmd.sel == SEL_MAXD) begin
                res_push  = 1'b1;
                res.value = max_dist[cmd.idx[1:0]];
              end else if (cmd.sel == SEL_SEEN) begin
                res_push  = 1'b1;
                res.value = seen;
              end else begin
                state_next = ST_RDATA;
              end
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      ST_RDATA: begin
        res_push   = 1'b1;
        res.value  = 32'(rdata);
        state_next = ST_IDLE;
      end
      ST_PREP: state_next = ST_STEP;
      ST_STEP: begin
        if (step_en) state_next = ST_WR;
        else if (step == LastStep) state_next = ST_FIN;
      end
      ST_WR: begin
        we = 1'b1;
        state_next = (step == LastStep) ? ST_FIN : ST_STEP;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer registers and per-symbol state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      pos_valid <= '0;
      recent    <= '0;
      seen      <= '0;
      for (int i = 0; i < 4; i++) begin
        last_pos[i] <= '0;
        max_dist[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          sym      <= cmd.sym;
          clr_addr <= '0;
          if (cmd_pop && cmd.op == OP_CLEAR) begin
            pos_valid <= '0;
            recent    <= '0;
            seen      <= '0;
            for (int i = 0; i < 4; i++) begin
              last_pos[i] <= '0;
              max_dist[i] <= '0;
            end
          end
        end
        ST_PREP: begin
          step     <= 3'd0;
          dist_bin <= (gap >= 32'(DistanceBins)) ? TopBin : gap[BW-1:0];
          if (pos_valid[sym] && gap > max_dist[sym]) max_dist[sym] <= gap;
        end
        ST_STEP: begin
          if (!step_en && step != LastStep) step <= step + 3'd1;
        end
        ST_WR: begin
          if (step != LastStep) step <= step + 3'd1;
        end
        ST_FIN: begin
          recent         <= {sym, recent[7:2]};
          pos_valid[sym] <= 1'b1;
          last_pos[sym]  <= seen;
          if (seen != 32'hFFFF_FFFF) seen <= seen + 32'd1;
        end
        default: step <= step;
      endcase
    end
  end

endmodule

// ===== hdl/nucleotide_kmer_statistics.sv =====
// top level of the k-mer statistics block
// Requests enter through a two-entry queue and results leave through another.
// In the back end a character is taken, set up, run through six update steps
// that each check and read a histogram bin or k-mer table, with a write-back for
// each one it updates, and finished. A k-mer or histogram table read is answered
// from memory in the state after it is taken; other requests are answered when
// taken. After reset and after every clear request the counter memory is swept
// to zero, one entry a cycle, during which no request is processed.
module nucleotide_kmer_statistics import nks_pkg::*; #(
  parameter int DistanceBins = DIST_BINS_DEFAULT,
  parameter int CounterWidth = COUNTER_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  symbol_char,
  input  logic [2:0]  table_select,
  input  logic [9:0]  read_index,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] read_value
);

  cmd_t in_cmd;
  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res;
  res_t res_out;
  logic res_full;
  logic res_push;

  // request decode
  nks_front #(.DistanceBins(DistanceBins)) u_front (
    .req_type(req_type), .symbol_char(symbol_char), .table_select(table_select),
    .read_index(read_index), .cmd(in_cmd)
  );

  // decoupling queue
  nks_fifo #(.item_t(cmd_t)) u_cmd_q (
    .clk(clk), .rst(rst), .wr(push), .wdata(in_cmd), .full(full),
    .rd(cmd_pop), .rdata(cmd), .empty(cmd_empty)
  );

  // execution
  nks_back #(.DistanceBins(DistanceBins), .CounterWidth(CounterWidth)) u_back (
    .clk(clk), .rst(rst), .cmd_empty(cmd_empty), .cmd(cmd), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res(res)
  );

  // result queue
  nks_fifo #(.item_t(res_t)) u_res_q (
    .clk(clk), .rst(rst), .wr(res_push), .wdata(res), .full(res_full),
    .rd(pop), .rdata(res_out), .empty(empty)
  );

  assign status     = res_out.status;
  assign read_value = res_out.value;

endmodule
